// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the iBUS frame receiver modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, clk, rst_n, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

// ===== hw/rtl/ibfr_pkg.sv =====
// Shared types and constants of the iBUS frame receiver.
package ibfr_pkg;

  localparam int CHANNELS = 14;

  localparam logic [7:0]  HDR_FIRST  = 8'h20;
  localparam logic [7:0]  HDR_SECOND = 8'h40;
  localparam logic [15:0] HDR_SUM    = 16'h0060;
  localparam logic [15:0] CKSUM_BASE = 16'hFFFF;

  localparam int PAYLOAD_LEN = 30;
  localparam int SUM_LEN     = 28;
  localparam int IDX_W       = 5;
  localparam int MEM_AW      = IDX_W + 1;
  localparam int CH_W        = 4;

  typedef struct packed {
    logic              en;
    logic [MEM_AW-1:0] addr;
    logic [7:0]        data;
  } store_wr_t;

  typedef struct packed {
    logic not_empty;
    logic full;
    logic head_ok;
  } fifo_status_t;

endpackage

// ===== hw/rtl/ibfr_front.sv =====
// Front end: header hunt, payload store writes and checksum check.
module ibfr_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_rx_byte,
  input  logic                q_full,
  output logic                push,
  output logic                push_ok,
  output ibfr_pkg::store_wr_t store_wr
);
  import ibfr_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT1 = 3'b001,
    PH_HUNT2 = 3'b010,
    PH_STORE = 3'b100
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [15:0]      sum_r, sum_nxt;
  logic [7:0]       lo_r, lo_nxt;
  logic             bank_r, bank_nxt;
  logic             accept;
  logic             last_byte;

  assign in_ready  = !((phase_r == PH_STORE) && q_full);
  assign accept    = in_valid && in_ready;
  assign last_byte = (cnt_r == IDX_W'(PAYLOAD_LEN - 1));

  assign store_wr.en   = accept && (phase_r == PH_STORE);
  assign store_wr.addr = {bank_r, cnt_r};
  assign store_wr.data = in_rx_byte;

  assign push    = accept && (phase_r == PH_STORE) && last_byte;
  assign push_ok = ((CKSUM_BASE - sum_r) == {in_rx_byte, lo_r});

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    lo_nxt    = lo_r;
    bank_nxt  = bank_r;
    if (accept) begin
      case (phase_r)
        PH_HUNT1: begin
          if (in_rx_byte == HDR_FIRST) phase_nxt = PH_HUNT2;
        end
        PH_HUNT2: begin
          if (in_rx_byte == HDR_SECOND) begin
            phase_nxt = PH_STORE;
            cnt_nxt   = '0;
            sum_nxt   = HDR_SUM;
          end
        end
        PH_STORE: begin
          if (cnt_r < IDX_W'(SUM_LEN)) sum_nxt = sum_r + {8'd0, in_rx_byte};
          if (cnt_r == IDX_W'(SUM_LEN)) lo_nxt = in_rx_byte;
          if (last_byte) begin
            phase_nxt = PH_HUNT1;
            cnt_nxt   = '0;
            bank_nxt  = !bank_r;
          end else begin
            cnt_nxt = cnt_r + IDX_W'(1);
          end
        end
        default: phase_nxt = PH_HUNT1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT1;
      cnt_r   <= '0;
      sum_r   <= '0;
      bank_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
      bank_r  <= bank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r <= lo_nxt;
  end

endmodule

// ===== hw/rtl/ibfr_fifo.sv =====
// Two-entry queue of finished frames (checksum verdict per frame).
`include "assert_macros.svh"
module ibfr_fifo (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  logic                   push_ok,
  input  logic                   pop,
  output ibfr_pkg::fifo_status_t status
);
  import ibfr_pkg::*;

  logic [1:0] ok_r;
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign status.not_empty = (count_r != 2'd0);
  assign status.full      = (count_r == 2'd2);
  assign status.head_ok   = ok_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop) rd_ptr_r <= !rd_ptr_r;
      if (push && !pop) count_r <= count_r + 2'd1;
      else if (pop && !push) count_r <= count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) ok_r[wr_ptr_r] <= push_ok;
  end

  `ASSERT_IMPL(a_no_overflow, clk, rst_n, push, !status.full, "frame pushed into full queue")
  `ASSERT_IMPL(a_no_underflow, clk, rst_n, pop, count_r != 2'd0, "frame popped from empty queue")
  `ASSERT_NEXT(a_count_grows, clk, rst_n, push && !pop, count_r != 2'd0, "count lost a push")

endmodule

// ===== hw/rtl/ibfr_back.sv =====
// Back end: double-banked payload store and channel result emitter.
`include "assert_macros.svh"
module ibfr_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ibfr_pkg::store_wr_t    store_wr,
  input  ibfr_pkg::fifo_status_t q_status,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [3:0]             out_channel_index,
  output logic [11:0]            out_channel_value,
  output logic                   out_checksum_ok,
  output logic                   out_last_channel
);
  import ibfr_pkg::*;

  typedef enum logic [2:0] {
    BK_IDLE = 3'b001,
    BK_READ = 3'b010,
    BK_SHOW = 3'b100
  } bk_state_t;

  logic [7:0] store_mem [0:(1 << MEM_AW) - 1];

  bk_state_t        state_r, state_nxt;
  logic [CH_W-1:0]  ch_r, ch_nxt;
  logic             bank_r, bank_nxt;
  logic [7:0]       lo_q;
  logic [7:0]       hi_q;
  logic             is_last;

  assign is_last = (ch_r == CH_W'(CHANNELS - 1));

  always_ff @(posedge clk) begin
    if (store_wr.en) store_mem[store_wr.addr] <= store_wr.data;
  end

  always_ff @(posedge clk) begin
    if (state_r == BK_READ) begin
      lo_q <= store_mem[{bank_r, ch_r, 1'b0}];
      hi_q <= store_mem[{bank_r, ch_r, 1'b1}];
    end
  end

  assign out_valid         = (state_r == BK_SHOW);
  assign out_channel_index = ch_r;
  assign out_channel_value = {hi_q[3:0], lo_q};
  assign out_checksum_ok   = q_status.head_ok;
  assign out_last_channel  = is_last;
  assign pop               = out_valid && out_ready && is_last;

  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    bank_nxt  = bank_r;
    case (state_r)
      BK_IDLE: begin
        if (q_status.not_empty) begin
          state_nxt = BK_READ;
          ch_nxt    = '0;
        end
      end
      BK_READ: state_nxt = BK_SHOW;
      BK_SHOW: begin
        if (out_ready) begin
          if (is_last) begin
            state_nxt = BK_IDLE;
            bank_nxt  = !bank_r;
          end else begin
            state_nxt = BK_READ;
            ch_nxt    = ch_r + CH_W'(1);
          end
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      ch_r    <= '0;
      bank_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
      bank_r  <= bank_nxt;
    end
  end

  `ASSERT_IMPL(a_show_has_frame, clk, rst_n, out_valid, q_status.not_empty, "result without frame")
  `ASSERT_IMPL(a_read_bank_safe, clk, rst_n, store_wr.en && (state_r != BK_IDLE),
    store_wr.addr[MEM_AW-1] != bank_r, "payload write into bank being read")

endmodule

// ===== hw/rtl/ibus_frame_receiver.sv =====
// iBUS frame receiver top level: byte parser, frame queue and channel emitter.
// Input: one byte per cycle; stalls only on a payload byte while the frame queue holds two frames.
// The first channel result of a frame follows its 30th payload byte through the frame queue and the emitter read state.
// Output: each channel result is read from the store into the output registers, then held until out_ready takes it.
// Reset clears parser, queue and emitter control; the payload store and data registers are not cleared.
module ibus_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_channel_index,
  output logic [11:0] out_channel_value,
  output logic        out_checksum_ok,
  output logic        out_last_channel
);
  import ibfr_pkg::*;

  store_wr_t    store_wr;
  fifo_status_t q_status;
  logic         push;
  logic         push_ok;
  logic         pop;

  ibfr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .q_full     (q_status.full),
    .push       (push),
    .push_ok    (push_ok),
    .store_wr   (store_wr)
  );

  ibfr_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_ok (push_ok),
    .pop     (pop),
    .status  (q_status)
  );

  ibfr_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .store_wr          (store_wr),
    .q_status          (q_status),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_channel_index (out_channel_index),
    .out_channel_value (out_channel_value),
    .out_checksum_ok   (out_checksum_ok),
    .out_last_channel  (out_last_channel)
  );

endmodule
